>>> rtl/twodo_pkg.sv
// shared types, constants and helper functions of the tracking wheel odometry block
`timescale 1ns / 1ps
`default_nettype none
package twodo_pkg;

  localparam int DIST_BITS    = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int OFS_BITS     = 24;
  localparam int CFG_IDX_BITS = 3;

  // pi in Q30 and one in Q30
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_OFFSET   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BACK_OFFSET    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_USE_IMU        = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WHEELS_PRESENT = 3'd4;

  // series evaluations, in the order they run
  localparam logic [2:0] JOB_SINC = 3'd0;
  localparam logic [2:0] JOB_SIN1 = 3'd1;
  localparam logic [2:0] JOB_COS1 = 3'd2;
  localparam logic [2:0] JOB_SIN2 = 3'd3;
  localparam logic [2:0] JOB_COS2 = 3'd4;

  // rounded products of the final rotation
  localparam logic [2:0] SLOT_LX_DB = 3'd0;
  localparam logic [2:0] SLOT_LX_OB = 3'd1;
  localparam logic [2:0] SLOT_LY_YA = 3'd2;
  localparam logic [2:0] SLOT_LY_OA = 3'd3;
  localparam logic [2:0] SLOT_DX_C  = 3'd4;
  localparam logic [2:0] SLOT_DX_S  = 3'd5;
  localparam logic [2:0] SLOT_DY_S  = 3'd6;
  localparam logic [2:0] SLOT_DY_C  = 3'd7;

  typedef struct packed {
    logic signed [DIST_BITS-1:0] right_total;
    logic signed [DIST_BITS-1:0] left_total;
    logic signed [DIST_BITS-1:0] back_total;
    logic [ANGLE_BITS-1:0]       imu_angle;
  } in_t;

  typedef struct packed {
    logic signed [DIST_BITS-1:0] pos_x;
    logic signed [DIST_BITS-1:0] pos_y;
    logic [ANGLE_BITS-1:0]       heading_angle;
    logic                        held;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_WDEN, OP_WCHK, OP_WDIV, OP_WRND, OP_XMUL, OP_SINIT,
    OP_SM1, OP_SM2, OP_DLOAD, OP_DSTEP, OP_SACC, OP_MLO, OP_MHI, OP_MADD, OP_FIN
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] job;
    logic [3:0] kidx;
    logic       last;
    logic [2:0] slot;
  } cmd_t;

  typedef struct packed {
    logic held;
    logic use_imu;
    logic wsat;
  } stat_t;

  function automatic logic is_cos(input logic [2:0] job);
    return (job == JOB_COS1) || (job == JOB_COS2);
  endfunction

  // number of terms of a series
  function automatic logic [3:0] ser_len(input logic [2:0] job);
    return (job == JOB_SINC) ? 4'd9 : 4'd6;
  endfunction

  // divisor of term k: (2k-1)(2k) for cosine, (2k)(2k+1) otherwise
  function automatic logic [8:0] ser_div(input logic [2:0] job, input logic [3:0] k);
    logic [9:0] e;
    logic [9:0] p;
    e = {5'd0, k, 1'b0};
    if (is_cos(job)) begin
      p = e * (e - 10'd1);
    end else begin
      p = e * (e + 10'd1);
    end
    return p[8:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/twodo_dp.sv
// datapath: state, shared multiplier, serial dividers, series and rotation arithmetic
`timescale 1ns / 1ps
`default_nettype none
module twodo_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire twodo_pkg::in_t                       in_data_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [twodo_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [twodo_pkg::OFS_BITS-1:0]       cfg_data_i,
  input  wire twodo_pkg::cmd_t                      cmd_i,
  output twodo_pkg::stat_t                          stat_o,
  output twodo_pkg::out_t                           out_data_o
);

  localparam logic [15:0] HALF = 16'h8000;

  // configuration
  logic [23:0] right_ofs_q, left_ofs_q, back_ofs_q;
  logic        use_imu_q;
  logic [2:0]  wp_q;

  // persistent state
  logic [31:0]        last_r_q, last_l_q, last_b_q;
  logic signed [31:0] pose_x_q, pose_y_q;
  logic [15:0]        pose_h_q;
  logic               held_out_q;

  // per request working registers
  logic signed [31:0] dr_q, dl_q, db_q;
  logic signed [15:0] dth_q;
  logic [15:0]        newh_q;
  logic               held_q;
  logic [63:0]        p_q;
  logic [35:0]        ph_q;
  logic [56:0]        wrem_q;
  logic [15:0]        wq_q;
  logic               wsat_q;
  logic [31:0]        x_q, term_q, sum_q, sin_q, dvd_q, k_q;
  logic [8:0]         drem_q;
  logic signed [31:0] sh_q, sa_q, ca_q;
  logic signed [39:0] lx_q, ly_q, dx_q, dy_q;

  // sine and cosine of an angle of 2^17 units per turn from the two series
  function automatic logic [63:0] map_sc(input logic [16:0] ang, input logic [31:0] sv,
                                         input logic [31:0] cv);
    logic        sw;
    logic [31:0] s0, c0;
    sw = ang[14:0] > 15'h4000;
    s0 = sw ? cv : sv;
    c0 = sw ? sv : cv;
    case (ang[16:15])
      2'd0:    return {s0, c0};
      2'd1:    return {c0, 32'd0 - s0};
      2'd2:    return {32'd0 - s0, 32'd0 - c0};
      default: return {32'd0 - c0, s0};
    endcase
  endfunction

  // deltas and heading test at request time
  logic [24:0] ofs_sum;
  logic [31:0] dr_new, dl_new, db_new;
  assign ofs_sum = {1'b0, right_ofs_q} + {1'b0, left_ofs_q};
  assign dr_new  = in_data_i.right_total - last_r_q;
  assign dl_new  = in_data_i.left_total - last_l_q;
  assign db_new  = in_data_i.back_total - last_b_q;

  // wheel heading division
  logic [32:0] diff, diff_mag;
  logic [56:0] den, shl;
  logic        wsat_now;
  logic [57:0] rem2, rem2_sub;
  logic        wge, wrnd;
  logic [16:0] q17;
  logic [15:0] qf, wdth;
  assign diff     = {dr_q[31], dr_q} - {dl_q[31], dl_q};
  assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
  assign den      = p_q[56:0];
  assign shl      = {diff_mag[26:0], 30'd0};
  assign wsat_now = (|diff_mag[32:27]) | (shl >= den);
  assign rem2     = {wrem_q, 1'b0};
  assign rem2_sub = rem2 - {1'b0, den};
  assign wge      = rem2 >= {1'b0, den};
  assign wrnd     = rem2 >= {1'b0, den};

  always_comb begin
    q17 = {1'b0, wq_q} + {16'd0, wrnd};
    if (wsat_q || (q17 > {1'b0, HALF})) begin
      q17 = {1'b0, HALF};
    end
    qf = q17[15:0];
    if (diff[32]) begin
      wdth = 16'd0 - qf;
    end else begin
      wdth = (qf == HALF) ? (HALF - 16'd1) : qf;
    end
  end

  // angle operands
  logic [15:0] dth_mag;
  logic [16:0] ang1, ang2, ang_sel;
  logic        swap;
  logic [15:0] xr, xmul_a;
  assign dth_mag = dth_q[15] ? (16'd0 - dth_q) : dth_q;
  assign ang1    = {dth_q[15], dth_q};
  assign ang2    = {newh_q, 1'b0} - {dth_q[15], dth_q};
  assign ang_sel = ((cmd_i.job == twodo_pkg::JOB_SIN1) || (cmd_i.job == twodo_pkg::JOB_COS1))
                   ? ang1 : ang2;
  assign swap    = ang_sel[14:0] > 15'h4000;
  assign xr      = swap ? (HALF - {1'b0, ang_sel[14:0]}) : {1'b0, ang_sel[14:0]};
  assign xmul_a  = (cmd_i.job == twodo_pkg::JOB_SINC) ? dth_mag : xr;

  // rotation product operands
  logic signed [39:0] ob, ya, oa, ma;
  logic signed [32:0] mb, k33, c2;
  logic [39:0] a_abs;
  logic [32:0] b_abs;
  logic        mneg, sh31;
  always_comb begin
    ob  = wp_q[2] ? {16'd0, back_ofs_q} : 40'd0;
    k33 = {1'b0, k_q};
    c2  = {sh_q, 1'b0};
    case (wp_q[1:0])
      2'b11: begin
        ya = {{8{dr_q[31]}}, dr_q} + {{8{dl_q[31]}}, dl_q};
        oa = {16'd0, left_ofs_q} - {16'd0, right_ofs_q};
      end
      2'b01: begin
        ya = {{8{dr_q[31]}}, dr_q};
        oa = 40'd0 - {16'd0, right_ofs_q};
      end
      2'b10: begin
        ya = {{8{dl_q[31]}}, dl_q};
        oa = {16'd0, left_ofs_q};
      end
      default: begin
        ya = 40'd0;
        oa = 40'd0;
      end
    endcase
    case (cmd_i.slot)
      twodo_pkg::SLOT_LX_DB: begin ma = {{8{db_q[31]}}, db_q}; mb = k33; end
      twodo_pkg::SLOT_LX_OB: begin ma = ob; mb = c2; end
      twodo_pkg::SLOT_LY_YA: begin ma = ya; mb = k33; end
      twodo_pkg::SLOT_LY_OA: begin ma = oa; mb = c2; end
      twodo_pkg::SLOT_DX_C:  begin ma = ly_q; mb = {ca_q[31], ca_q}; end
      twodo_pkg::SLOT_DX_S:  begin ma = lx_q; mb = {sa_q[31], sa_q}; end
      twodo_pkg::SLOT_DY_S:  begin ma = ly_q; mb = {sa_q[31], sa_q}; end
      default:               begin ma = lx_q; mb = {ca_q[31], ca_q}; end
    endcase
    a_abs = ma[39] ? (40'd0 - ma) : ma;
    b_abs = mb[32] ? (33'd0 - mb) : mb;
    mneg  = ma[39] ^ mb[32];
    sh31  = ((cmd_i.slot == twodo_pkg::SLOT_LY_YA) || (cmd_i.slot == twodo_pkg::SLOT_LY_OA))
            && (wp_q[1:0] == 2'b11);
  end

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    case (cmd_i.op)
      twodo_pkg::OP_WDEN: begin mul_a = {7'd0, ofs_sum}; mul_b = twodo_pkg::PI_Q30; end
      twodo_pkg::OP_XMUL: begin mul_a = {16'd0, xmul_a}; mul_b = twodo_pkg::PI_Q30; end
      twodo_pkg::OP_SM1:  begin mul_a = term_q; mul_b = x_q; end
      twodo_pkg::OP_SM2:  begin mul_a = p_q[61:30]; mul_b = x_q; end
      twodo_pkg::OP_MLO:  begin mul_a = a_abs[31:0]; mul_b = b_abs[31:0]; end
      twodo_pkg::OP_MHI:  begin mul_a = {28'd0, a_abs[35:32]}; mul_b = b_abs[31:0]; end
      default:            begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  // rounded product, half away from zero
  logic [67:0]        tot;
  logic [39:0]        rmag;
  logic signed [39:0] mval;
  assign tot  = {ph_q, 32'd0} + {4'd0, p_q} + (sh31 ? (68'd1 << 30) : (68'd1 << 29));
  assign rmag = sh31 ? {3'd0, tot[67:31]} : {2'd0, tot[67:30]};
  assign mval = mneg ? (40'd0 - rmag) : rmag;

  // constant divider, four quotient bits a step
  logic [8:0]  dsor, dr_rem;
  logic [31:0] dv;
  logic [9:0]  dt;
  assign dsor = twodo_pkg::ser_div(cmd_i.job, cmd_i.kidx);
  always_comb begin
    dr_rem = drem_q;
    dv     = dvd_q;
    dt     = 10'd0;
    for (int i = 0; i < 4; i++) begin
      dt = {dr_rem, dv[31]};
      dv = {dv[30:0], 1'b0};
      if (dt >= {1'b0, dsor}) begin
        dt    = dt - {1'b0, dsor};
        dv[0] = 1'b1;
      end
      dr_rem = dt[8:0];
    end
  end

  // series accumulation
  logic [31:0] x_new, xs, sum_new;
  logic [63:0] sc;
  assign x_new   = p_q[47:16];
  assign xs      = ((cmd_i.job == twodo_pkg::JOB_SINC) || (cmd_i.job == twodo_pkg::JOB_SIN1) ||
                    (cmd_i.job == twodo_pkg::JOB_SIN2)) ? x_new : x_q;
  assign sum_new = cmd_i.kidx[0] ? (sum_q - dvd_q) : (sum_q + dvd_q);
  assign sc      = map_sc(ang_sel, sin_q, sum_new);

  // pose update with saturation
  logic [40:0] sx, sy;
  logic [31:0] satx, saty;
  function automatic logic [31:0] sat32(input logic [40:0] v);
    if (!v[40] && (|v[39:31])) return 32'h7FFF_FFFF;
    if (v[40] && !(&v[39:31])) return 32'h8000_0000;
    return v[31:0];
  endfunction
  assign sx   = {{9{pose_x_q[31]}}, pose_x_q} + {dx_q[39], dx_q};
  assign sy   = {{9{pose_y_q[31]}}, pose_y_q} + {dy_q[39], dy_q};
  assign satx = sat32(sx);
  assign saty = sat32(sy);

  // configuration and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_ofs_q <= '0;
      left_ofs_q  <= '0;
      back_ofs_q  <= '0;
      use_imu_q   <= 1'b1;
      wp_q        <= 3'b111;
      last_r_q    <= '0;
      last_l_q    <= '0;
      last_b_q    <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      pose_h_q    <= '0;
      held_out_q  <= 1'b0;
      held_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          twodo_pkg::CFG_RIGHT_OFFSET:   right_ofs_q <= cfg_data_i;
          twodo_pkg::CFG_LEFT_OFFSET:    left_ofs_q  <= cfg_data_i;
          twodo_pkg::CFG_BACK_OFFSET:    back_ofs_q  <= cfg_data_i;
          twodo_pkg::CFG_USE_IMU:        use_imu_q   <= cfg_data_i[0];
          twodo_pkg::CFG_WHEELS_PRESENT: wp_q        <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (cmd_i.op == twodo_pkg::OP_ACCEPT) begin
        if (wp_q[0]) last_r_q <= in_data_i.right_total;
        if (wp_q[1]) last_l_q <= in_data_i.left_total;
        if (wp_q[2]) last_b_q <= in_data_i.back_total;
        held_q <= !use_imu_q && ((wp_q[1:0] != 2'b11) || (ofs_sum == 25'd0));
      end
      if (cmd_i.op == twodo_pkg::OP_FIN) begin
        held_out_q <= held_q;
        if (!held_q) begin
          pose_x_q <= satx;
          pose_y_q <= saty;
          pose_h_q <= newh_q;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      twodo_pkg::OP_ACCEPT: begin
        dr_q   <= wp_q[0] ? dr_new : 32'd0;
        dl_q   <= wp_q[1] ? dl_new : 32'd0;
        db_q   <= wp_q[2] ? db_new : 32'd0;
        dth_q  <= in_data_i.imu_angle - pose_h_q;
        newh_q <= in_data_i.imu_angle;
      end
      twodo_pkg::OP_WDEN: p_q <= mul_p;
      twodo_pkg::OP_WCHK: begin
        wsat_q <= wsat_now;
        wrem_q <= shl;
        wq_q   <= '0;
      end
      twodo_pkg::OP_WDIV: begin
        wrem_q <= wge ? rem2_sub[56:0] : rem2[56:0];
        wq_q   <= {wq_q[14:0], wge};
      end
      twodo_pkg::OP_WRND: begin
        dth_q  <= wdth;
        newh_q <= pose_h_q + wdth;
      end
      twodo_pkg::OP_XMUL: p_q <= mul_p;
      twodo_pkg::OP_SINIT: begin
        x_q    <= xs;
        term_q <= twodo_pkg::is_cos(cmd_i.job) || (cmd_i.job == twodo_pkg::JOB_SINC)
                  ? twodo_pkg::ONE_Q30 : xs;
        sum_q  <= twodo_pkg::is_cos(cmd_i.job) || (cmd_i.job == twodo_pkg::JOB_SINC)
                  ? twodo_pkg::ONE_Q30 : xs;
      end
      twodo_pkg::OP_SM1, twodo_pkg::OP_SM2: p_q <= mul_p;
      twodo_pkg::OP_DLOAD: begin
        dvd_q  <= p_q[61:30];
        drem_q <= '0;
      end
      twodo_pkg::OP_DSTEP: begin
        dvd_q  <= dv;
        drem_q <= dr_rem;
      end
      twodo_pkg::OP_SACC: begin
        term_q <= dvd_q;
        sum_q  <= sum_new;
        if (cmd_i.last) begin
          case (cmd_i.job)
            twodo_pkg::JOB_SINC: k_q <= sum_new;
            twodo_pkg::JOB_SIN1, twodo_pkg::JOB_SIN2: sin_q <= sum_new;
            twodo_pkg::JOB_COS1: sh_q <= sc[63:32];
            default: begin
              sa_q <= sc[63:32];
              ca_q <= sc[31:0];
            end
          endcase
        end
      end
      twodo_pkg::OP_MLO: p_q <= mul_p;
      twodo_pkg::OP_MHI: ph_q <= mul_p[35:0];
      twodo_pkg::OP_MADD: begin
        case (cmd_i.slot)
          twodo_pkg::SLOT_LX_DB: lx_q <= mval;
          twodo_pkg::SLOT_LX_OB: lx_q <= lx_q + mval;
          twodo_pkg::SLOT_LY_YA: ly_q <= mval;
          twodo_pkg::SLOT_LY_OA: ly_q <= ly_q + mval;
          twodo_pkg::SLOT_DX_C:  dx_q <= mval;
          twodo_pkg::SLOT_DX_S:  dx_q <= dx_q - mval;
          twodo_pkg::SLOT_DY_S:  dy_q <= mval;
          default:               dy_q <= dy_q + mval;
        endcase
      end
      default: ;
    endcase
  end

  assign stat_o.held    = held_q;
  assign stat_o.use_imu = use_imu_q;
  assign stat_o.wsat    = wsat_now;

  assign out_data_o.pos_x         = pose_x_q;
  assign out_data_o.pos_y         = pose_y_q;
  assign out_data_o.heading_angle = pose_h_q;
  assign out_data_o.held          = held_out_q;

endmodule
`default_nettype wire

>>> rtl/twodo_ctrl.sv
// controller: sequences the datapath through division, series and rotation steps
`timescale 1ns / 1ps
`default_nettype none
module twodo_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire twodo_pkg::stat_t  stat_i,
  output twodo_pkg::cmd_t        cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_WDEN, ST_WCHK, ST_WDIV, ST_WRND, ST_XMUL, ST_SINIT, ST_SM1,
    ST_SM2, ST_DLOAD, ST_DSTEP, ST_SACC, ST_MLO, ST_MHI, ST_MADD, ST_FIN
  } state_e;

  state_e     state_q;
  logic [3:0] cnt_q, kidx_q;
  logic [2:0] job_q, slot_q;
  logic       out_valid_q;
  logic       fin_go;
  logic       last;

  assign fin_go = !out_valid_q || out_ready_i;
  assign last   = kidx_q == twodo_pkg::ser_len(job_q);

  // command decode
  always_comb begin
    cmd_o.job  = job_q;
    cmd_o.kidx = kidx_q;
    cmd_o.last = last;
    cmd_o.slot = slot_q;
    case (state_q)
      ST_IDLE:  cmd_o.op = in_valid_i ? twodo_pkg::OP_ACCEPT : twodo_pkg::OP_NONE;
      ST_WDEN:  cmd_o.op = twodo_pkg::OP_WDEN;
      ST_WCHK:  cmd_o.op = twodo_pkg::OP_WCHK;
      ST_WDIV:  cmd_o.op = twodo_pkg::OP_WDIV;
      ST_WRND:  cmd_o.op = twodo_pkg::OP_WRND;
      ST_XMUL:  cmd_o.op = twodo_pkg::OP_XMUL;
      ST_SINIT: cmd_o.op = twodo_pkg::OP_SINIT;
      ST_SM1:   cmd_o.op = twodo_pkg::OP_SM1;
      ST_SM2:   cmd_o.op = twodo_pkg::OP_SM2;
      ST_DLOAD: cmd_o.op = twodo_pkg::OP_DLOAD;
      ST_DSTEP: cmd_o.op = twodo_pkg::OP_DSTEP;
      ST_SACC:  cmd_o.op = twodo_pkg::OP_SACC;
      ST_MLO:   cmd_o.op = twodo_pkg::OP_MLO;
      ST_MHI:   cmd_o.op = twodo_pkg::OP_MHI;
      ST_MADD:  cmd_o.op = twodo_pkg::OP_MADD;
      ST_FIN:   cmd_o.op = fin_go ? twodo_pkg::OP_FIN : twodo_pkg::OP_NONE;
      default:  cmd_o.op = twodo_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  // state and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      kidx_q      <= '0;
      job_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_DISP;
        ST_DISP: begin
          job_q <= twodo_pkg::JOB_SINC;
          if (stat_i.held) state_q <= ST_FIN;
          else if (stat_i.use_imu) state_q <= ST_XMUL;
          else state_q <= ST_WDEN;
        end
        ST_WDEN: state_q <= ST_WCHK;
        ST_WCHK: begin
          cnt_q   <= '0;
          state_q <= stat_i.wsat ? ST_WRND : ST_WDIV;
        end
        ST_WDIV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd14) state_q <= ST_WRND;
        end
        ST_WRND: state_q <= ST_XMUL;
        ST_XMUL: state_q <= ST_SINIT;
        ST_SINIT: begin
          kidx_q  <= 4'd1;
          state_q <= ST_SM1;
        end
        ST_SM1:   state_q <= ST_SM2;
        ST_SM2:   state_q <= ST_DLOAD;
        ST_DLOAD: begin
          cnt_q   <= '0;
          state_q <= ST_DSTEP;
        end
        ST_DSTEP: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd7) state_q <= ST_SACC;
        end
        ST_SACC: begin
          if (!last) begin
            kidx_q  <= kidx_q + 4'd1;
            state_q <= ST_SM1;
          end else if (job_q == twodo_pkg::JOB_COS2) begin
            slot_q  <= '0;
            state_q <= ST_MLO;
          end else begin
            job_q <= job_q + 3'd1;
            if ((job_q + 3'd1 == twodo_pkg::JOB_SIN1) || (job_q + 3'd1 == twodo_pkg::JOB_SIN2))
              state_q <= ST_XMUL;
            else
              state_q <= ST_SINIT;
          end
        end
        ST_MLO:  state_q <= ST_MHI;
        ST_MHI:  state_q <= ST_MADD;
        ST_MADD: begin
          slot_q  <= slot_q + 3'd1;
          state_q <= (slot_q == twodo_pkg::SLOT_DY_C) ? ST_FIN : ST_MLO;
        end
        ST_FIN: begin
          if (fin_go) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/tracking_wheel_odometry.sv
// Tracking wheel odometry: top level joining controller and datapath.
// Request to result runs five Taylor series sharing one multiplier and one
// four-bit-a-step divider; the wheel heading adds a serial division, skipped when
// the wheel turn saturates, and a held pose skips all of them. One request at a
// time; a waiting result stalls only the next one. Reset clears pose and totals,
// zeroes the offsets and selects the IMU heading with all wheels; no result pending.
`timescale 1ns / 1ps
`default_nettype none
module tracking_wheel_odometry (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire twodo_pkg::in_t                      in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output twodo_pkg::out_t                          out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [twodo_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [twodo_pkg::OFS_BITS-1:0]      cfg_data_i
);

  twodo_pkg::cmd_t  cmd;
  twodo_pkg::stat_t stat;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  twodo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  twodo_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

>>> tb/odometry_checker.sv
// pose predictor and result checker for the tracking wheel odometry block
`timescale 1ns / 1ps
module odometry_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  twodo_pkg::in_t    in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  twodo_pkg::out_t   out_data_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i,
  output int                fail_count_o,
  output int                pending_count_o
);
  import twodo_pkg::*;

  localparam bit [63:0] PI_RAD = 64'd3373259426;
  localparam bit [63:0] UNITY  = 64'd1 << 30;

  // register copies
  logic [23:0] ofs_right, ofs_left, ofs_back;
  logic        imu_mode;
  logic [2:0]  fitted;

  // pose and last wheel totals
  logic [31:0] prev_right, prev_left, prev_back;
  longint      track_x, track_y;
  logic [15:0] track_head;

  out_t pose_fifo[$];

  // rounded product a*b / 2^s, half away from zero
  function automatic longint round_mul(longint a, longint b, int s);
    bit [63:0] ua, ub, hi, lo, r;
    bit        neg;
    ua  = a < 0 ? -a : a;
    ub  = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    hi  = (ua >> 32) * ub;
    lo  = (ua & 64'hFFFF_FFFF) * ub + (64'd1 << (s - 1));
    r   = (hi << (32 - s)) + (lo >> s);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // truncating taylor series in Q30; cosine form uses (2k-1)(2k) divisors
  function automatic bit [63:0] taylor(bit [63:0] first, bit [63:0] x, int terms, bit cosine);
    bit [63:0] term, sum, dv;
    term = first;
    sum  = first;
    for (int k = 1; k <= terms; k++) begin
      dv   = cosine ? (2 * k - 1) * (2 * k) : (2 * k) * (2 * k + 1);
      term = ((((term * x) >> 30) * x) >> 30) / dv;
      if (k & 1) sum -= term;
      else sum += term;
    end
    return sum;
  endfunction

  // sine and cosine of a binary angle with 2^b units per turn
  task automatic sin_cos(input bit [63:0] a, input int b, output longint s, output longint c);
    bit [63:0] qd, q, r, x;
    longint    s0, c0;
    qd = 64'd1 << (b - 2);
    a  = a & ((64'd1 << b) - 1);
    q  = (a >> (b - 2)) & 3;
    r  = a & (qd - 1);
    if (2 * r <= qd) begin
      x  = (r * PI_RAD) >> (b - 1);
      s0 = taylor(x, x, 6, 1'b0);
      c0 = taylor(UNITY, x, 6, 1'b1);
    end else begin
      x  = ((qd - r) * PI_RAD) >> (b - 1);
      s0 = taylor(UNITY, x, 6, 1'b1);
      c0 = taylor(x, x, 6, 1'b0);
    end
    case (q)
      0: begin s = s0;  c = c0;  end
      1: begin s = c0;  c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  // heading change from wheel difference, saturated at half a turn
  function automatic longint wheel_rotation(longint diff, bit [63:0] span);
    bit [63:0] mag, half, den, q, rem;
    mag  = diff < 0 ? -diff : diff;
    half = 64'd1 << 15;
    den  = PI_RAD * span;
    q    = 0;
    if (mag >= (64'd1 << 27) || (mag << 30) >= den) begin
      q = half;
    end else begin
      rem = mag << 30;
      for (int i = 0; i < 15; i++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q   = q | 1;
        end
      end
      if (rem * 2 >= den) q++;
      if (q > half) q = half;
    end
    if (diff < 0) return -longint'(q);
    return q == half ? longint'(half - 1) : longint'(q);
  endfunction

  function automatic longint clamp_dist(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // advance the pose by one request and return the expected result
  task automatic advance_pose(input in_t d, output out_t res);
    longint    dr, dl, db, dth, k, sh, unused, sa, ca, c2, ob, ya, oa, lx, ly, dx, dy;
    logic [15:0] newh;
    bit [63:0] span, h;
    bit        hold;
    int        ys;
    dr = 0; dl = 0; db = 0; dth = 0; ya = 0; oa = 0; ys = 30;
    hold = 1'b0;
    newh = track_head;
    if (fitted[0]) begin
      dr = longint'($signed(32'(d.right_total - prev_right)));
      prev_right = d.right_total;
    end
    if (fitted[1]) begin
      dl = longint'($signed(32'(d.left_total - prev_left)));
      prev_left = d.left_total;
    end
    if (fitted[2]) begin
      db = longint'($signed(32'(d.back_total - prev_back)));
      prev_back = d.back_total;
    end
    if (imu_mode) begin
      newh = d.imu_angle;
      dth  = longint'($signed(16'(newh - track_head)));
    end else begin
      span = 64'(ofs_right) + 64'(ofs_left);
      if (fitted[1:0] != 2'b11 || span == 0) begin
        hold = 1'b1;
      end else begin
        dth  = wheel_rotation(dr - dl, span);
        newh = 16'(track_head + dth[15:0]);
      end
    end
    if (!hold) begin
      h = ((dth < 0 ? -dth : dth) * PI_RAD) >> 16;
      k = taylor(UNITY, h, 9, 1'b0);
      sin_cos(64'(dth), 17, sh, unused);
      c2 = 2 * sh;
      sin_cos((64'(newh) << 1) - 64'(dth), 17, sa, ca);
      ob = fitted[2] ? longint'(ofs_back) : 0;
      if (fitted[1:0] == 2'b11) begin
        ya = dr + dl;
        oa = longint'(ofs_left) - longint'(ofs_right);
        ys = 31;
      end else if (fitted[0]) begin
        ya = dr;
        oa = -longint'(ofs_right);
      end else if (fitted[1]) begin
        ya = dl;
        oa = longint'(ofs_left);
      end
      lx = round_mul(db, k, 30) + round_mul(ob, c2, 30);
      ly = round_mul(ya, k, ys) + round_mul(oa, c2, ys);
      dx = round_mul(ly, ca, 30) - round_mul(lx, sa, 30);
      dy = round_mul(ly, sa, 30) + round_mul(lx, ca, 30);
      track_x    = clamp_dist(track_x + dx);
      track_y    = clamp_dist(track_y + dy);
      track_head = newh;
    end
    res.pos_x         = track_x[31:0];
    res.pos_y         = track_y[31:0];
    res.heading_angle = track_head;
    res.held          = hold;
  endtask

  // watch the three channels; results are checked before the new request is queued
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want, got;
    if (!rst_ni) begin
      ofs_right <= '0; ofs_left <= '0; ofs_back <= '0;
      imu_mode <= 1'b1; fitted <= 3'b111;
      prev_right <= '0; prev_left <= '0; prev_back <= '0;
      track_x <= 0; track_y <= 0; track_head <= '0;
      pose_fifo.delete();
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RIGHT_OFFSET:   ofs_right = cfg_data_i;
          CFG_LEFT_OFFSET:    ofs_left  = cfg_data_i;
          CFG_BACK_OFFSET:    ofs_back  = cfg_data_i;
          CFG_USE_IMU:        imu_mode  = cfg_data_i[0];
          CFG_WHEELS_PRESENT: fitted    = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (pose_fifo.size() == 0) begin
          $error("result with no request outstanding: %p", got);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = pose_fifo.pop_front();
          if (got.pos_x !== want.pos_x) begin
            $error("pos_x expected %0d got %0d", $signed(want.pos_x), $signed(got.pos_x));
            fail_count_o = fail_count_o + 1;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("pos_y expected %0d got %0d", $signed(want.pos_y), $signed(got.pos_y));
            fail_count_o = fail_count_o + 1;
          end
          if (got.heading_angle !== want.heading_angle) begin
            $error("heading_angle expected %0d got %0d", want.heading_angle,
                   got.heading_angle);
            fail_count_o = fail_count_o + 1;
          end
          if (got.held !== want.held) begin
            $error("held expected %0b got %0b", want.held, got.held);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_pose(in_data_i, want);
        pose_fifo = {pose_fifo, want};
      end
      pending_count_o = pose_fifo.size();
    end
  end

endmodule

>>> tb/testbench.sv
// stimulus and verdict for the tracking wheel odometry block
`timescale 1ns / 1ps
module testbench;
  import twodo_pkg::*;

  localparam logic [2:0]  ALL_WHEELS = 3'b111;
  localparam logic [23:0] INCH       = 24'h01_0000;
  localparam int          SETTLE     = 460;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  int          fail_count, pending_count;

  // running wheel totals and heading fed to the block
  logic [31:0] sum_right = '0, sum_left = '0, sum_back = '0;
  logic [15:0] imu_now = '0;
  bit          quiet = 1'b0;
  int          stall_left = 0;

  always #1 clk = ~clk;

  tracking_wheel_odometry i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  odometry_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready  <= 1'b1;
      stall_left <= $urandom_range(0, 20);
    end
  end

  // one request, with an optional gap first
  task automatic send_request(input in_t d);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // move the wheels by the given deltas and report a new imu heading
  task automatic move(input int dr, input int dl, input int db, input logic [15:0] imu);
    sum_right = sum_right + dr;
    sum_left  = sum_left + dl;
    sum_back  = sum_back + db;
    imu_now   = imu;
    send_request('{right_total: sum_right, left_total: sum_left,
                   back_total: sum_back, imu_angle: imu});
  endtask

  // raw totals, any values at all
  task automatic jump(input logic [31:0] r, input logic [31:0] l, input logic [31:0] b,
                      input logic [15:0] imu);
    sum_right = r; sum_left = l; sum_back = b; imu_now = imu;
    send_request('{right_total: r, left_total: l, back_total: b, imu_angle: imu});
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(input logic [23:0] r, input logic [23:0] l, input logic [23:0] b,
                       input logic [23:0] imu, input logic [23:0] wp);
    write_reg(CFG_RIGHT_OFFSET, r);
    write_reg(CFG_LEFT_OFFSET, l);
    write_reg(CFG_BACK_OFFSET, b);
    write_reg(CFG_USE_IMU, imu);
    write_reg(CFG_WHEELS_PRESENT, wp);
  endtask

  function automatic logic [23:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom);
      default: return 24'($urandom_range(INCH / 2, 12 * INCH));
    endcase
  endfunction

  function automatic int small_step();
    return int'($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  initial begin
    int n_items;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, imu heading: zero motion, straight, turns, wraps, saturation
    move(0, 0, 0, 16'd0);
    move(32'sd65536, 32'sd65536, 0, 16'd0);
    move(32'sd131072, 32'sd65536, 32'sd65536, 16'd16384);
    move(-32'sd65536, 32'sd65536, -32'sd65536, 16'd49152);
    move(32'sd65536, 32'sd65536, 0, 16'hFFFF);
    jump(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
    jump(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000);
    repeat (3) move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
    repeat (3) move(32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 16'h4000);
    drain();

    // wheel heading with a zero offset sum holds the pose
    setup(24'd0, 24'd0, 24'd0, 24'd0, ALL_WHEELS);
    move(32'sd65536, -32'sd65536, 0, 16'd0);
    drain();

    // wheel heading: small turn, saturating turns both ways, straight
    setup(5 * INCH, 5 * INCH, 3 * INCH, 24'd0, ALL_WHEELS);
    move(32'sd65536, -32'sd65536, 32'sd32768, 16'd0);
    move(32'sd50000000, -32'sd50000000, 0, 16'd0);
    move(-32'sd50000000, 32'sd50000000, 0, 16'd0);
    move(32'sd65536, 32'sd65536, 0, 16'd0);
    drain();

    // single wheel sets and no wheels, then a wheel heading without both wheels
    setup(INCH, 2 * INCH, 24'hFF_FFFF, 24'd1, 24'd1);
    move(32'sd65536, 32'sd9999, 32'sd777, 16'd1000);
    drain();
    write_reg(CFG_WHEELS_PRESENT, 24'd2);
    move(32'sd9999, 32'sd65536, 32'sd777, 16'd2000);
    drain();
    write_reg(CFG_WHEELS_PRESENT, 24'd4);
    move(32'sd9999, 32'sd9999, 32'sd65536, 16'd3000);
    drain();
    write_reg(CFG_WHEELS_PRESENT, 24'd0);
    move(32'sd9999, 32'sd9999, 32'sd65536, 16'd4000);
    drain();
    write_reg(CFG_USE_IMU, 24'hFF_FFFE);
    write_reg(CFG_WHEELS_PRESENT, 24'hFF_FFF9);
    move(32'sd65536, -32'sd65536, 0, 16'd0);
    drain();
    write_reg(CFG_WHEELS_PRESENT + 3'd1, 24'hFF_FFFF);
    write_reg(3'd7, 24'd0);
    drain();

    // largest offsets in wheel mode
    setup(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0, ALL_WHEELS);
    move(32'sd1 << 24, -32'sd1 << 24, 32'sd123456, 16'd0);
    move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
    drain();

    // random phases, each under a fresh setting
    for (int ph = 0; ph < 8; ph++) begin
      setup(pick_offset(), pick_offset(), pick_offset(),
            ($urandom_range(0, 1) ? 24'd1 : 24'($urandom)),
            ($urandom_range(0, 3) != 0 ? ALL_WHEELS : 24'($urandom)));
      if (ph == 7) setup(24'd1, 24'd1, 24'd1, 24'd0, ALL_WHEELS);
      n_items = 228;
      for (int i = 0; i < n_items; i++) begin
        if (ph == 7 && i > 100) quiet = 1'b1;
        if (ph == 3 && i == 110) drain();
        case ($urandom_range(0, 9))
          0: jump($urandom, $urandom, $urandom, 16'($urandom));
          1: move($urandom, $urandom, $urandom, 16'($urandom));
          default: move(small_step(), small_step(), small_step(),
                        16'(imu_now + $urandom_range(0, 4000) - 2000));
        endcase
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
